// ----- hw/rtl/grapheme_cluster_segmenter_macros.svh -----
// Assertion macros for the grapheme cluster segmenter.
// Included by the top level; each macro expects i_clk and i_rst_n in scope.
`ifndef GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH
`define GRAPHEME_CLUSTER_SEGMENTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/gcs_pkg.sv -----
// Shared types, class codes and code point range tables for the
// grapheme cluster segmenter. No dependencies.
package gcs_pkg;

    localparam int CP_W  = 21;
    localparam int POS_W = 32;
    localparam int CLS_W = 4;

    localparam logic [CLS_W-1:0] CL_OTHER   = 4'd0;
    localparam logic [CLS_W-1:0] CL_CR      = 4'd1;
    localparam logic [CLS_W-1:0] CL_LF      = 4'd2;
    localparam logic [CLS_W-1:0] CL_CONTROL = 4'd3;
    localparam logic [CLS_W-1:0] CL_EXTEND  = 4'd4;
    localparam logic [CLS_W-1:0] CL_ZWJ     = 4'd5;
    localparam logic [CLS_W-1:0] CL_RI      = 4'd6;
    localparam logic [CLS_W-1:0] CL_PREPEND = 4'd7;
    localparam logic [CLS_W-1:0] CL_SPACING = 4'd8;
    localparam logic [CLS_W-1:0] CL_HL      = 4'd9;
    localparam logic [CLS_W-1:0] CL_HV      = 4'd10;
    localparam logic [CLS_W-1:0] CL_HT      = 4'd11;
    localparam logic [CLS_W-1:0] CL_HLV     = 4'd12;
    localparam logic [CLS_W-1:0] CL_HLVT    = 4'd13;

    localparam logic [1:0] PROP_NONE    = 2'd0;
    localparam logic [1:0] PROP_EXTEND  = 2'd1;
    localparam logic [1:0] PROP_SPACING = 2'd2;
    localparam logic [1:0] PROP_CONTROL = 2'd3;

    localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;
    localparam logic [CP_W-1:0] CP_ZWJ       = 21'h00200D;
    localparam logic [CP_W-1:0] CP_RI_LO     = 21'h01F1E6;
    localparam logic [CP_W-1:0] CP_RI_HI     = 21'h01F1FF;
    localparam logic [CP_W-1:0] CP_SYL_LO    = 21'h00AC00;
    localparam logic [CP_W-1:0] CP_SYL_HI    = 21'h00D7A3;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

    // Syllable offset fits 14 bits; LV iff offset is a multiple of the trailing count.
    localparam int SYL_OFF_W      = 14;
    localparam int HANGUL_T_COUNT = 28;
    localparam int RECIP_SHIFT    = 18;
    localparam int HANGUL_RECIP   = (2**RECIP_SHIFT + HANGUL_T_COUNT - 1) / HANGUL_T_COUNT;
    localparam int QUOT_W         = 9;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_span;

    localparam int N_HL = 2;
    localparam t_span HL_SPANS [N_HL] = '{
        '{21'h001100, 21'h00115F}, '{21'h00A960, 21'h00A97C}
    };

    localparam int N_HV = 2;
    localparam t_span HV_SPANS [N_HV] = '{
        '{21'h001160, 21'h0011A7}, '{21'h00D7B0, 21'h00D7C6}
    };

    localparam int N_HT = 2;
    localparam t_span HT_SPANS [N_HT] = '{
        '{21'h0011A8, 21'h0011FF}, '{21'h00D7CB, 21'h00D7FB}
    };

    localparam int N_EXTRA_EXT = 4;
    localparam t_span EXTRA_EXT_SPANS [N_EXTRA_EXT] = '{
        '{21'h00200C, 21'h00200C}, '{21'h00FF9E, 21'h00FF9F},
        '{21'h01F3FB, 21'h01F3FF}, '{21'h0E0020, 21'h0E007F}
    };

    localparam int N_PREPEND = 16;
    localparam t_span PREPEND_SPANS [N_PREPEND] = '{
        '{21'h000600, 21'h000605}, '{21'h0006DD, 21'h0006DD}, '{21'h00070F, 21'h00070F},
        '{21'h000890, 21'h000891}, '{21'h0008E2, 21'h0008E2}, '{21'h000D4E, 21'h000D4E},
        '{21'h0110BD, 21'h0110BD}, '{21'h0110CD, 21'h0110CD}, '{21'h0111C2, 21'h0111C3},
        '{21'h01193F, 21'h01193F}, '{21'h011941, 21'h011941}, '{21'h011A3A, 21'h011A3A},
        '{21'h011A84, 21'h011A89}, '{21'h011D46, 21'h011D46}, '{21'h011F02, 21'h011F02},
        '{21'h013430, 21'h01343F}
    };

    localparam int N_PICTO = 26;
    localparam t_span PICTO_SPANS [N_PICTO] = '{
        '{21'h0000A9, 21'h0000A9}, '{21'h0000AE, 21'h0000AE}, '{21'h00203C, 21'h002049},
        '{21'h002122, 21'h002139}, '{21'h002194, 21'h002199}, '{21'h0021A9, 21'h0021AA},
        '{21'h00231A, 21'h00231B}, '{21'h002328, 21'h002328}, '{21'h0023CF, 21'h0023CF},
        '{21'h0023E9, 21'h0023FA}, '{21'h0024C2, 21'h0024C2}, '{21'h0025AA, 21'h0025AB},
        '{21'h0025B6, 21'h0025B6}, '{21'h0025C0, 21'h0025C0}, '{21'h0025FB, 21'h0025FE},
        '{21'h002600, 21'h0027BF}, '{21'h002934, 21'h002935}, '{21'h002B05, 21'h002B07},
        '{21'h002B1B, 21'h002B1C}, '{21'h002B50, 21'h002B50}, '{21'h002B55, 21'h002B55},
        '{21'h003030, 21'h003030}, '{21'h00303D, 21'h00303D}, '{21'h003297, 21'h003297},
        '{21'h003299, 21'h003299}, '{21'h01F000, 21'h01FAFF}
    };

    // Classification of one code point, handed to the rule stage.
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             picto;
        logic             bad_cp;
    } t_item_info;

    // One result transaction.
    typedef struct packed {
        logic             boundary;
        logic [POS_W-1:0] position;
        logic             invalid;
    } t_result;

    function automatic logic is_ctl(input logic [CLS_W-1:0] c);
        return (c == CL_CR) || (c == CL_LF) || (c == CL_CONTROL);
    endfunction

endpackage

// ----- hw/rtl/grapheme_cluster_segmenter.sv -----
// Grapheme cluster segmenter, top level. One code point per transaction goes in,
// one result per transaction comes out: an input register feeds the classifier and
// boundary rules, whose result lands in an output register, so a new code point is
// taken every cycle while the output side does not stall; the feedback of text
// state through the rule stage is the path that sets this rate. Code point zero,
// surrogates, values above 0x10FFFF and a full position counter give an invalid
// result and restart the text; a transaction with tlast restarts the text too.
// Depends on gcs_pkg, gcs_classify, gcs_state.
`include "grapheme_cluster_segmenter_macros.svh"

module grapheme_cluster_segmenter
    import gcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [22:21] table_property, [23] zero
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] position
    output logic [1:0]  m_axis_tuser    // [0] boundary_before, [1] invalid
);

    logic            r_s1_valid;
    logic [CP_W-1:0] r_in_cp;
    logic [1:0]      r_in_prop;
    logic            r_in_last;
    logic            r_out_valid;
    t_result         r_out;

    logic            w_adv;
    logic            w_step;
    t_item_info      w_info;
    t_result         w_res;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_s1_valid && w_adv;
    assign s_axis_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cp   <= s_axis_tdata[CP_W-1:0];
            r_in_prop <= s_axis_tdata[CP_W +: 2];
            r_in_last <= s_axis_tlast;
        end
    end

    gcs_classify u_classify (
        .i_code_point     (r_in_cp),
        .i_table_property (r_in_prop),
        .o_info           (w_info)
    );

    gcs_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_info  (w_info),
        .i_last  (r_in_last),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.position;
    assign m_axis_tuser  = {r_out.invalid, r_out.boundary};

    `GCS_ASSERT_SAME(a_invalid_no_boundary, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "invalid result carries a boundary")
    `GCS_ASSERT_NEXT(a_restart_clears_pos, w_step && (w_res.invalid || r_in_last), w_res.position == '0, "position not cleared after text restart")
    `GCS_ASSERT_SAME(a_first_is_boundary, r_s1_valid && (w_res.position == '0) && !w_res.invalid, w_res.boundary, "first code point of a text lacks a boundary")

endmodule

// ----- hw/rtl/gcs_classify.sv -----
// Code point classifier: fixed range compares, syllable LV/LVT split and
// table property merge. Depends on gcs_pkg.
module gcs_classify
    import gcs_pkg::*;
(
    input  logic [CP_W-1:0] i_code_point,
    input  logic [1:0]      i_table_property,
    output t_item_info      o_info
);

    logic                          w_hl;
    logic                          w_hv;
    logic                          w_ht;
    logic                          w_ext;
    logic                          w_pre;
    logic                          w_pic;
    logic                          w_syl;
    logic                          w_lv;
    logic [SYL_OFF_W-1:0]          w_off;
    logic [2*SYL_OFF_W-1:0]        w_prod;
    logic [QUOT_W-1:0]             w_quot;
    logic [SYL_OFF_W-1:0]          w_back;

    always_comb begin
        w_hl  = 1'b0;
        w_hv  = 1'b0;
        w_ht  = 1'b0;
        w_ext = 1'b0;
        w_pre = 1'b0;
        w_pic = 1'b0;
        for (int i = 0; i < N_HL; i++) begin
            w_hl |= (i_code_point >= HL_SPANS[i].lo) && (i_code_point <= HL_SPANS[i].hi);
        end
        for (int i = 0; i < N_HV; i++) begin
            w_hv |= (i_code_point >= HV_SPANS[i].lo) && (i_code_point <= HV_SPANS[i].hi);
        end
        for (int i = 0; i < N_HT; i++) begin
            w_ht |= (i_code_point >= HT_SPANS[i].lo) && (i_code_point <= HT_SPANS[i].hi);
        end
        for (int i = 0; i < N_EXTRA_EXT; i++) begin
            w_ext |= (i_code_point >= EXTRA_EXT_SPANS[i].lo)
                  && (i_code_point <= EXTRA_EXT_SPANS[i].hi);
        end
        for (int i = 0; i < N_PREPEND; i++) begin
            w_pre |= (i_code_point >= PREPEND_SPANS[i].lo)
                  && (i_code_point <= PREPEND_SPANS[i].hi);
        end
        for (int i = 0; i < N_PICTO; i++) begin
            w_pic |= (i_code_point >= PICTO_SPANS[i].lo) && (i_code_point <= PICTO_SPANS[i].hi);
        end
    end

    // Offset modulo trailing count by reciprocal multiply.
    assign w_syl  = (i_code_point >= CP_SYL_LO) && (i_code_point <= CP_SYL_HI);
    assign w_off  = SYL_OFF_W'(i_code_point - CP_SYL_LO);
    assign w_prod = (2*SYL_OFF_W)'(w_off) * (2*SYL_OFF_W)'(HANGUL_RECIP);
    assign w_quot = w_prod[RECIP_SHIFT +: QUOT_W];
    assign w_back = SYL_OFF_W'(SYL_OFF_W'(w_quot) * SYL_OFF_W'(HANGUL_T_COUNT));
    assign w_lv   = (w_back == w_off);

    always_comb begin
        o_info.picto  = w_pic;
        o_info.bad_cp = (i_code_point == '0) || (i_code_point > CP_MAX)
                     || ((i_code_point >= CP_SURR_LO) && (i_code_point <= CP_SURR_HI));
        if (i_code_point == CP_CR) begin
            o_info.cls = CL_CR;
        end else if (i_code_point == CP_LF) begin
            o_info.cls = CL_LF;
        end else if (i_code_point == CP_ZWJ) begin
            o_info.cls = CL_ZWJ;
        end else if ((i_code_point >= CP_RI_LO) && (i_code_point <= CP_RI_HI)) begin
            o_info.cls = CL_RI;
        end else if (w_hl) begin
            o_info.cls = CL_HL;
        end else if (w_hv) begin
            o_info.cls = CL_HV;
        end else if (w_ht) begin
            o_info.cls = CL_HT;
        end else if (w_syl) begin
            o_info.cls = w_lv ? CL_HLV : CL_HLVT;
        end else if ((i_table_property == PROP_EXTEND) || w_ext) begin
            o_info.cls = CL_EXTEND;
        end else if (w_pre) begin
            o_info.cls = CL_PREPEND;
        end else if (i_table_property == PROP_SPACING) begin
            o_info.cls = CL_SPACING;
        end else if (i_table_property == PROP_CONTROL) begin
            o_info.cls = CL_CONTROL;
        end else begin
            o_info.cls = CL_OTHER;
        end
    end

endmodule

// ----- hw/rtl/gcs_state.sv -----
// Boundary rules and text state: previous class, indicator parity, emoji
// joiner flags and position counter. Depends on gcs_pkg.
module gcs_state
    import gcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item_info i_info,
    input  logic       i_last,
    output t_result    o_res
);

    logic [CLS_W-1:0] r_prev_class, n_prev_class;
    logic             r_at_start,   n_at_start;
    logic             r_ri_odd,     n_ri_odd;
    logic             r_pic_ext,    n_pic_ext;
    logic             r_zwj_pic,    n_zwj_pic;
    logic [POS_W-1:0] r_pos,        n_pos;

    logic             w_bad;
    logic             w_brk;
    logic             w_cut;
    logic [CLS_W-1:0] w_c;

    assign w_c   = i_info.cls;
    assign w_bad = i_info.bad_cp || (r_pos == '1);

    always_comb begin
        if ((r_prev_class == CL_CR) && (w_c == CL_LF)) begin
            w_brk = 1'b0;
        end else if (is_ctl(r_prev_class) || is_ctl(w_c)) begin
            w_brk = 1'b1;
        end else if ((r_prev_class == CL_HL) && ((w_c == CL_HL) || (w_c == CL_HV)
                     || (w_c == CL_HLV) || (w_c == CL_HLVT))) begin
            w_brk = 1'b0;
        end else if (((r_prev_class == CL_HLV) || (r_prev_class == CL_HV))
                     && ((w_c == CL_HV) || (w_c == CL_HT))) begin
            w_brk = 1'b0;
        end else if (((r_prev_class == CL_HLVT) || (r_prev_class == CL_HT))
                     && (w_c == CL_HT)) begin
            w_brk = 1'b0;
        end else if ((w_c == CL_EXTEND) || (w_c == CL_ZWJ) || (w_c == CL_SPACING)) begin
            w_brk = 1'b0;
        end else if (r_prev_class == CL_PREPEND) begin
            w_brk = 1'b0;
        end else if ((r_prev_class == CL_ZWJ) && r_zwj_pic && i_info.picto) begin
            w_brk = 1'b0;
        end else if ((r_prev_class == CL_RI) && (w_c == CL_RI) && r_ri_odd) begin
            w_brk = 1'b0;
        end else begin
            w_brk = 1'b1;
        end
    end

    assign w_cut = r_at_start || w_brk;

    always_comb begin
        n_prev_class = r_prev_class;
        n_at_start   = r_at_start;
        n_ri_odd     = r_ri_odd;
        n_pic_ext    = r_pic_ext;
        n_zwj_pic    = r_zwj_pic;
        n_pos        = r_pos;
        if (i_step) begin
            if (w_bad || i_last) begin
                n_prev_class = CL_OTHER;
                n_at_start   = 1'b1;
                n_ri_odd     = 1'b0;
                n_pic_ext    = 1'b0;
                n_zwj_pic    = 1'b0;
                n_pos        = '0;
            end else begin
                n_prev_class = w_c;
                n_at_start   = 1'b0;
                n_pos        = r_pos + POS_W'(1);
                if (w_cut) begin
                    n_ri_odd  = (w_c == CL_RI);
                    n_pic_ext = i_info.picto;
                    n_zwj_pic = 1'b0;
                end else begin
                    n_zwj_pic = (w_c == CL_ZWJ) && r_pic_ext;
                    if (w_c == CL_ZWJ) begin
                        n_pic_ext = 1'b0;
                    end else if (w_c != CL_EXTEND) begin
                        n_pic_ext = i_info.picto;
                    end
                    if (w_c == CL_RI) begin
                        n_ri_odd = (r_prev_class == CL_RI) ? !r_ri_odd : 1'b1;
                    end else begin
                        n_ri_odd = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= CL_OTHER;
            r_at_start   <= 1'b1;
            r_ri_odd     <= 1'b0;
            r_pic_ext    <= 1'b0;
            r_zwj_pic    <= 1'b0;
            r_pos        <= '0;
        end else begin
            r_prev_class <= n_prev_class;
            r_at_start   <= n_at_start;
            r_ri_odd     <= n_ri_odd;
            r_pic_ext    <= n_pic_ext;
            r_zwj_pic    <= n_zwj_pic;
            r_pos        <= n_pos;
        end
    end

    assign o_res.boundary = !w_bad && w_cut;
    assign o_res.position = r_pos;
    assign o_res.invalid  = w_bad;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for grapheme_cluster_segmenter: directed rows, then random text
// streams with emoji, Hangul and flag sequences, checked against an in-bench predictor.
// Depends on gcs_pkg for class and table property codes.
module tb
    import gcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1424;
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_UCS_SPANS    = 52;

    typedef enum logic [2:0] {
        SK_EXTEND, SK_PREPEND, SK_PICTO, SK_HL, SK_HV, SK_HT
    } span_kind_e;

    typedef struct packed {
        logic        boundary;
        logic [31:0] position;
        logic        invalid;
    } cp_verdict_t;

    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  prop;
        logic        last;
        logic        fixed;
        logic        boundary;
        logic [31:0] position;
        logic        invalid;
    } stim_row_t;

    // {kind, first, last}
    localparam logic [44:0] UCS_SPANS [N_UCS_SPANS] = '{
        {SK_EXTEND, 21'h00200C, 21'h00200C}, {SK_EXTEND, 21'h00FF9E, 21'h00FF9F},
        {SK_EXTEND, 21'h01F3FB, 21'h01F3FF}, {SK_EXTEND, 21'h0E0020, 21'h0E007F},
        {SK_PREPEND, 21'h000600, 21'h000605}, {SK_PREPEND, 21'h0006DD, 21'h0006DD},
        {SK_PREPEND, 21'h00070F, 21'h00070F}, {SK_PREPEND, 21'h000890, 21'h000891},
        {SK_PREPEND, 21'h0008E2, 21'h0008E2}, {SK_PREPEND, 21'h000D4E, 21'h000D4E},
        {SK_PREPEND, 21'h0110BD, 21'h0110BD}, {SK_PREPEND, 21'h0110CD, 21'h0110CD},
        {SK_PREPEND, 21'h0111C2, 21'h0111C3}, {SK_PREPEND, 21'h01193F, 21'h01193F},
        {SK_PREPEND, 21'h011941, 21'h011941}, {SK_PREPEND, 21'h011A3A, 21'h011A3A},
        {SK_PREPEND, 21'h011A84, 21'h011A89}, {SK_PREPEND, 21'h011D46, 21'h011D46},
        {SK_PREPEND, 21'h011F02, 21'h011F02}, {SK_PREPEND, 21'h013430, 21'h01343F},
        {SK_PICTO, 21'h0000A9, 21'h0000A9}, {SK_PICTO, 21'h0000AE, 21'h0000AE},
        {SK_PICTO, 21'h00203C, 21'h002049}, {SK_PICTO, 21'h002122, 21'h002139},
        {SK_PICTO, 21'h002194, 21'h002199}, {SK_PICTO, 21'h0021A9, 21'h0021AA},
        {SK_PICTO, 21'h00231A, 21'h00231B}, {SK_PICTO, 21'h002328, 21'h002328},
        {SK_PICTO, 21'h0023CF, 21'h0023CF}, {SK_PICTO, 21'h0023E9, 21'h0023FA},
        {SK_PICTO, 21'h0024C2, 21'h0024C2}, {SK_PICTO, 21'h0025AA, 21'h0025AB},
        {SK_PICTO, 21'h0025B6, 21'h0025B6}, {SK_PICTO, 21'h0025C0, 21'h0025C0},
        {SK_PICTO, 21'h0025FB, 21'h0025FE}, {SK_PICTO, 21'h002600, 21'h0027BF},
        {SK_PICTO, 21'h002934, 21'h002935}, {SK_PICTO, 21'h002B05, 21'h002B07},
        {SK_PICTO, 21'h002B1B, 21'h002B1C}, {SK_PICTO, 21'h002B50, 21'h002B50},
        {SK_PICTO, 21'h002B55, 21'h002B55}, {SK_PICTO, 21'h003030, 21'h003030},
        {SK_PICTO, 21'h00303D, 21'h00303D}, {SK_PICTO, 21'h003297, 21'h003297},
        {SK_PICTO, 21'h003299, 21'h003299}, {SK_PICTO, 21'h01F000, 21'h01FAFF},
        {SK_HL, 21'h001100, 21'h00115F}, {SK_HL, 21'h00A960, 21'h00A97C},
        {SK_HV, 21'h001160, 21'h0011A7}, {SK_HV, 21'h00D7B0, 21'h00D7C6},
        {SK_HT, 21'h0011A8, 21'h0011FF}, {SK_HT, 21'h00D7CB, 21'h00D7FB}
    };

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{21'h000041, PROP_NONE,    1'b0, 1'b1, 1'b1, 32'd0, 1'b0},
        '{21'h00000D, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h00000A, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h000000, PROP_NONE,    1'b0, 1'b1, 1'b0, 32'd3, 1'b1},
        '{21'h10FFFF, PROP_NONE,    1'b0, 1'b1, 1'b1, 32'd0, 1'b0},
        '{21'h110000, PROP_NONE,    1'b0, 1'b1, 1'b0, 32'd1, 1'b1},
        '{21'h1FFFFF, PROP_CONTROL, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1},
        '{21'h00D800, PROP_EXTEND,  1'b0, 1'b1, 1'b0, 32'd0, 1'b1},
        '{21'h00DFFF, PROP_SPACING, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1},
        '{21'h00D7FF, PROP_SPACING, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0},
        '{21'h001100, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h00AC00, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h0011A8, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h00AC01, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h01F1E6, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h01F1FF, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h01F1E6, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h01F600, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h01F3FB, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h00200D, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h002764, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h000600, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h000041, PROP_NONE,    1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h000903, PROP_SPACING, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h00007F, PROP_CONTROL, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
        '{21'h000041, PROP_EXTEND,  1'b0, 1'b1, 1'b1, 32'd0, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [20:0] code_point, [22:21] table_property, [23] zero
    logic        s_axis_tlast;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // [31:0] position
    logic [1:0]  m_axis_tuser;   // [0] boundary_before, [1] invalid

    cp_verdict_t verdict_q [$];
    logic [22:0] pending_cps [$];
    int unsigned faults = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    logic [3:0]  prev_cls;
    bit          text_start;
    bit          ri_odd;
    bit          picto_open;
    bit          zwj_after_picto;
    logic [31:0] cp_index;

    grapheme_cluster_segmenter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic void restart_text();
        prev_cls        = CL_OTHER;
        text_start      = 1'b1;
        ri_odd          = 1'b0;
        picto_open      = 1'b0;
        zwj_after_picto = 1'b0;
        cp_index        = '0;
    endfunction

    function automatic bit in_kind(input logic [20:0] cp, input span_kind_e k);
        for (int i = 0; i < N_UCS_SPANS; i++) begin
            if (UCS_SPANS[i][44:42] == k && cp >= UCS_SPANS[i][41:21] &&
                cp <= UCS_SPANS[i][20:0])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic cp_verdict_t judge_code_point(input logic [20:0] cp,
                                                     input logic [1:0] prop,
                                                     input logic last);
        cp_verdict_t v;
        logic [3:0]  cls;
        bit          pic;
        bit          cut;
        v.position = cp_index;
        v.boundary = 1'b0;
        v.invalid  = 1'b1;
        if (cp == 21'd0 || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF) ||
            cp_index == '1) begin
            restart_text();
            return v;
        end

        pic = in_kind(cp, SK_PICTO);
        if (cp == 21'h00000D) cls = CL_CR;
        else if (cp == 21'h00000A) cls = CL_LF;
        else if (cp == 21'h00200D) cls = CL_ZWJ;
        else if (cp >= 21'h01F1E6 && cp <= 21'h01F1FF) cls = CL_RI;
        else if (in_kind(cp, SK_HL)) cls = CL_HL;
        else if (in_kind(cp, SK_HV)) cls = CL_HV;
        else if (in_kind(cp, SK_HT)) cls = CL_HT;
        else if (cp >= 21'h00AC00 && cp <= 21'h00D7A3)
            cls = (((cp - 21'h00AC00) % 21'd28) == 21'd0) ? CL_HLV : CL_HLVT;
        else if (prop == PROP_EXTEND || in_kind(cp, SK_EXTEND)) cls = CL_EXTEND;
        else if (in_kind(cp, SK_PREPEND)) cls = CL_PREPEND;
        else if (prop == PROP_SPACING) cls = CL_SPACING;
        else if (prop == PROP_CONTROL) cls = CL_CONTROL;
        else cls = CL_OTHER;

        if (text_start) cut = 1'b1;
        else if (prev_cls == CL_CR && cls == CL_LF) cut = 1'b0;
        else if (prev_cls inside {CL_CR, CL_LF, CL_CONTROL} ||
                 cls inside {CL_CR, CL_LF, CL_CONTROL}) cut = 1'b1;
        else if (prev_cls == CL_HL && cls inside {CL_HL, CL_HV, CL_HLV, CL_HLVT}) cut = 1'b0;
        else if (prev_cls inside {CL_HLV, CL_HV} && cls inside {CL_HV, CL_HT}) cut = 1'b0;
        else if (prev_cls inside {CL_HLVT, CL_HT} && cls == CL_HT) cut = 1'b0;
        else if (cls inside {CL_EXTEND, CL_ZWJ, CL_SPACING}) cut = 1'b0;
        else if (prev_cls == CL_PREPEND) cut = 1'b0;
        else if (prev_cls == CL_ZWJ && zwj_after_picto && pic) cut = 1'b0;
        else if (prev_cls == CL_RI && cls == CL_RI && ri_odd) cut = 1'b0;
        else cut = 1'b1;

        if (cut) begin
            ri_odd          = (cls == CL_RI);
            picto_open      = pic;
            zwj_after_picto = 1'b0;
        end else begin
            zwj_after_picto = (cls == CL_ZWJ) && picto_open;
            if (cls == CL_ZWJ) picto_open = 1'b0;
            else if (cls != CL_EXTEND) picto_open = pic;
            if (cls == CL_RI) ri_odd = (prev_cls == CL_RI) ? !ri_odd : 1'b1;
            else ri_odd = 1'b0;
        end
        prev_cls   = cls;
        text_start = 1'b0;
        cp_index   = cp_index + 32'd1;

        v.boundary = cut;
        v.invalid  = 1'b0;
        if (last) restart_text();
        return v;
    endfunction

    function automatic logic [20:0] cp_from(input span_kind_e k);
        int unsigned idx;
        do idx = $urandom_range(N_UCS_SPANS - 1);
        while (UCS_SPANS[idx][44:42] != k);
        return 21'($urandom_range(32'(UCS_SPANS[idx][20:0]), 32'(UCS_SPANS[idx][41:21])));
    endfunction

    function automatic void queue_cp(input logic [20:0] cp, input int unsigned noise_pct);
        logic [1:0] prop;
        prop = ($urandom_range(99) < noise_pct) ? 2'($urandom_range(3)) : PROP_NONE;
        pending_cps.push_back({prop, cp});
    endfunction

    function automatic void plan_text_run();
        int unsigned pick;
        int unsigned reps;
        pick = $urandom_range(99);
        if (pick < 20) begin
            queue_cp(cp_from(SK_PICTO), 5);
            if ($urandom_range(1) == 1) queue_cp(cp_from(SK_EXTEND), 5);
            queue_cp(21'h00200D, 5);
            queue_cp(cp_from(SK_PICTO), 5);
            if ($urandom_range(2) == 0) begin
                queue_cp(21'h00200D, 5);
                queue_cp(cp_from(SK_PICTO), 5);
            end
        end else if (pick < 32) begin
            reps = $urandom_range(2, 1);
            repeat (reps) queue_cp(cp_from(SK_HL), 5);
            case ($urandom_range(2))
                0: queue_cp(cp_from(SK_HV), 5);
                1: queue_cp(21'(32'h00AC00 + 28 * $urandom_range(398)), 5);
                default: queue_cp(21'($urandom_range(32'h00D7A3, 32'h00AC00)), 5);
            endcase
            if ($urandom_range(1) == 1) queue_cp(cp_from(SK_HT), 5);
        end else if (pick < 42) begin
            reps = $urandom_range(5, 1);
            repeat (reps) queue_cp(21'($urandom_range(32'h01F1FF, 32'h01F1E6)), 5);
        end else if (pick < 50) begin
            queue_cp(21'h00000D, 5);
            if ($urandom_range(1) == 1) queue_cp(21'h00000A, 5);
            else queue_cp(21'($urandom_range(32'h7E, 32'h20)), 5);
        end else if (pick < 56) begin
            queue_cp(cp_from(SK_PREPEND), 5);
            queue_cp(21'($urandom_range(32'h7E, 32'h20)), 5);
        end else begin
            pick = $urandom_range(99);
            if (pick < 30) queue_cp(21'($urandom_range(32'h7E, 32'h20)), 40);
            else if (pick < 40) queue_cp(21'($urandom_range(32'h10FFFF, 1)), 40);
            else if (pick < 48) queue_cp(cp_from(SK_EXTEND), 40);
            else if (pick < 54) queue_cp(21'h00200D, 40);
            else if (pick < 62) queue_cp(cp_from(SK_PICTO), 40);
            else if (pick < 66) queue_cp(cp_from(span_kind_e'($urandom_range(5, 3))), 40);
            else if (pick < 70) queue_cp(21'($urandom_range(32'h00D7A3, 32'h00AC00)), 40);
            else if (pick < 78) queue_cp(21'($urandom_range(32'h01F1FF, 32'h01F1E6)), 40);
            else if (pick < 84) queue_cp(21'($urandom_range(32'h1F, 1)), 40);
            else if (pick < 92) queue_cp(21'($urandom_range(32'h1FFFFF)), 40);
            else begin
                case ($urandom_range(2))
                    0: queue_cp(21'd0, 40);
                    1: queue_cp(21'($urandom_range(32'h00DFFF, 32'h00D800)), 40);
                    default: queue_cp(21'($urandom_range(32'h1FFFFF, 32'h110000)), 40);
                endcase
            end
        end
    endfunction

    task automatic send_cp(input logic [20:0] cp, input logic [1:0] prop, input logic last,
                           input logic fixed, input cp_verdict_t want);
        cp_verdict_t got;
        while (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, prop, cp};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = judge_code_point(cp, prop, last);
        verdict_q.push_back(fixed ? want : got);
    endtask

    initial begin : stimulus
        logic [22:0] nxt;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        restart_text();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++)
            send_cp(DIRECTED[i].cp, DIRECTED[i].prop, DIRECTED[i].last, DIRECTED[i].fixed,
                    {DIRECTED[i].boundary, DIRECTED[i].position, DIRECTED[i].invalid});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (pending_cps.size() == 0) plan_text_run();
            nxt = pending_cps.pop_front();
            send_cp(nxt[20:0], nxt[22:21], $urandom_range(99) < 4, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin : scoreboard
        cp_verdict_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: position=%0d boundary=%b invalid=%b",
                             m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            end else begin
                want = verdict_q.pop_front();
                if (want !== {m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]}) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: expected boundary=%b position=%0d invalid=%b, %s",
                                 want.boundary, want.position, want.invalid,
                                 $sformatf("got boundary=%b position=%0d invalid=%b",
                                           m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]));
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
